// ===== src/gcr_pkg.sv =====
// Shared types and constants for the glyph cell renderer.
// No dependencies; every other file in src but gcr_ram imports this package.
package gcr_pkg;

    localparam int GLYPH_WIDTH = 8;
    localparam int GLYPH_SHIFT = 3;
    localparam int COLOR_W     = 32;
    localparam int INDEX_W     = 24;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int BITS_W      = 8;
    localparam int CODE_W      = 8;

    localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_READY   = 2'd2;

    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_FONT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [CODE_W-1:0]  char_code;
        logic [8:0]         text_column;
        logic [7:0]         text_row;
        logic [COLOR_W-1:0] foreground;
        logic [COLOR_W-1:0] background;
        logic [3:0]         glyph_line;
        logic [BITS_W-1:0]  glyph_bits;
    } cmd_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] pixel0;
        logic [COLOR_W-1:0] pixel1;
        logic [COLOR_W-1:0] pixel2;
        logic [COLOR_W-1:0] pixel3;
        logic [COLOR_W-1:0] pixel4;
        logic [COLOR_W-1:0] pixel5;
        logic [COLOR_W-1:0] pixel6;
        logic [COLOR_W-1:0] pixel7;
        logic               last_row;
    } row_t;

    // One glyph row on its way from the sequencer to the pixel stage.
    typedef struct packed {
        logic [COLOR_W-1:0] foreground;
        logic [COLOR_W-1:0] background;
        logic [INDEX_W-1:0] pixel_index;
        logic               last_row;
    } issue_t;

endpackage

// ===== src/gcr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gcr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Read during write returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/gcr_row_seq.sv =====
// Command holding stage and row sequencer: checks draws, writes font rows,
// and issues one glyph row read per cycle while advance is high. Depends on gcr_pkg.
module gcr_row_seq #(
    parameter int GLYPH_HEIGHT  = 16,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  gcr_pkg::cmd_t                         cmd,
    input  logic [gcr_pkg::CFG_DATA_W-1:0]        screen_width,
    input  logic [gcr_pkg::CFG_DATA_W-1:0]        screen_height,
    input  logic                                  frame_ready,
    input  logic                                  advance,
    output logic                                  issue_valid,
    output gcr_pkg::issue_t                       issue,
    output logic [gcr_pkg::CODE_W+$clog2(GLYPH_HEIGHT)-1:0] rd_addr,
    output logic                                  wr_en,
    output logic [gcr_pkg::CODE_W+$clog2(GLYPH_HEIGHT)-1:0] wr_addr,
    output logic [gcr_pkg::BITS_W-1:0]            wr_data
);

    import gcr_pkg::*;

    localparam int LINE_W = $clog2(GLYPH_HEIGHT);
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int PX_W   = 9 + GLYPH_SHIFT;
    localparam int PY_W   = 8 + LINE_W;
    localparam int MAX_A  = (PX_W > PY_W) ? PX_W : PY_W;
    localparam int CMP_W  = ((MAX_A > DIM_W) ? MAX_A : DIM_W) + 1;
    localparam int PROD_W = PY_W + DIM_W;

    logic                hold_valid_reg, hold_valid_next;
    cmd_t                hold_reg, hold_next;
    logic                hold_ok_reg, hold_ok_next;
    logic                busy_reg, busy_next;
    logic [LINE_W-1:0]   line_reg, line_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [COLOR_W-1:0]  fg_reg, fg_next;
    logic [COLOR_W-1:0]  bg_reg, bg_next;
    logic [INDEX_W-1:0]  index_reg, index_next;

    logic [DIM_W-1:0]    width_clamped;
    logic [DIM_W-1:0]    height_clamped;
    logic [PX_W-1:0]     cmd_px;
    logic [PY_W-1:0]     cmd_py;
    logic                cmd_ok;
    logic [PX_W-1:0]     hold_px;
    logic [PY_W-1:0]     hold_py;
    logic [PROD_W-1:0]   base_prod;
    logic [INDEX_W-1:0]  base_index;
    logic                last_line;
    logic                issue_fire;
    logic                retire;
    logic                accept;

    always_comb
    begin
        width_clamped = (32'(screen_width) > MAX_DIMENSION)
                      ? DIM_W'(MAX_DIMENSION) : DIM_W'(screen_width);
        height_clamped = (32'(screen_height) > MAX_DIMENSION)
                       ? DIM_W'(MAX_DIMENSION) : DIM_W'(screen_height);

        cmd_px = PX_W'(cmd.text_column) << GLYPH_SHIFT;
        cmd_py = PY_W'(cmd.text_row) * PY_W'(GLYPH_HEIGHT);
        cmd_ok = frame_ready
              && (CMP_W'(cmd_px) + CMP_W'(GLYPH_WIDTH) <= CMP_W'(width_clamped))
              && (CMP_W'(cmd_py) + CMP_W'(GLYPH_HEIGHT) <= CMP_W'(height_clamped));

        hold_px    = PX_W'(hold_reg.text_column) << GLYPH_SHIFT;
        hold_py    = PY_W'(hold_reg.text_row) * PY_W'(GLYPH_HEIGHT);
        base_prod  = PROD_W'(hold_py) * PROD_W'(width_clamped);
        base_index = INDEX_W'(base_prod + PROD_W'(hold_px));
    end

    assign last_line  = (line_reg == LINE_W'(GLYPH_HEIGHT - 1));
    assign issue_fire = busy_reg && advance;
    // Hand the held command over once the last row of the current draw leaves.
    assign retire     = hold_valid_reg && (!busy_reg || (issue_fire && last_line));
    assign cmd_ready  = !hold_valid_reg || retire;
    assign accept     = cmd_valid && cmd_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        hold_ok_next    = hold_ok_reg;
        busy_next       = busy_reg;
        line_next       = line_reg;
        code_next       = code_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        index_next      = index_reg;

        if (retire)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept)
        begin
            hold_valid_next = 1'b1;
            hold_next       = cmd;
            hold_ok_next    = cmd_ok;
        end

        if (issue_fire)
        begin
            line_next  = line_reg + LINE_W'(1);
            index_next = index_reg + INDEX_W'(width_clamped);
            if (last_line)
            begin
                busy_next = 1'b0;
            end
        end

        if (retire && hold_reg.kind == KIND_DRAW && hold_ok_reg)
        begin
            busy_next  = 1'b1;
            line_next  = '0;
            code_next  = hold_reg.char_code;
            fg_next    = hold_reg.foreground;
            bg_next    = hold_reg.background;
            index_next = base_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            busy_reg       <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg    <= hold_next;
        hold_ok_reg <= hold_ok_next;
        line_reg    <= line_next;
        code_reg    <= code_next;
        fg_reg      <= fg_next;
        bg_reg      <= bg_next;
        index_reg   <= index_next;
    end

    assign issue_valid       = busy_reg;
    assign issue.foreground  = fg_reg;
    assign issue.background  = bg_reg;
    assign issue.pixel_index = index_reg;
    assign issue.last_row    = last_line;
    assign rd_addr           = {code_reg, line_reg};

    // Drop font rows past the glyph height.
    assign wr_en   = retire && hold_reg.kind == KIND_FONT
                  && int'(hold_reg.glyph_line) < GLYPH_HEIGHT;
    assign wr_addr = {hold_reg.char_code, LINE_W'(hold_reg.glyph_line)};
    assign wr_data = hold_reg.glyph_bits;

endmodule

// ===== src/gcr_pixel_stage.sv =====
// Pixel stage: aligns issued rows with font read data, expands the glyph
// byte into eight colors and holds the output register. Depends on gcr_pkg.
module gcr_pixel_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        issue_valid,
    input  gcr_pkg::issue_t             issue,
    input  logic [gcr_pkg::BITS_W-1:0]  rd_data,
    output logic                        advance,
    output logic                        row_valid,
    input  logic                        row_ready,
    output gcr_pkg::row_t               row
);

    import gcr_pkg::*;

    logic   s1_valid_reg, s1_valid_next;
    issue_t s1_reg, s1_next;
    logic   out_valid_reg, out_valid_next;
    row_t   out_reg, out_next;
    logic   out_advance;
    logic [COLOR_W-1:0] pix [8];

    assign out_advance = !out_valid_reg || row_ready;
    // The font RAM read is enabled by the same signal, so its data holds too.
    assign advance     = !s1_valid_reg || out_advance;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            pix[k] = rd_data[7 - k] ? s1_reg.foreground : s1_reg.background;
        end
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            s1_valid_next = issue_valid;
            s1_next       = issue;
        end
        if (out_advance)
        begin
            out_valid_next       = s1_valid_reg;
            out_next.pixel_index = s1_reg.pixel_index;
            out_next.pixel0      = pix[0];
            out_next.pixel1      = pix[1];
            out_next.pixel2      = pix[2];
            out_next.pixel3      = pix[3];
            out_next.pixel4      = pix[4];
            out_next.pixel5      = pix[5];
            out_next.pixel6      = pix[6];
            out_next.pixel7      = pix[7];
            out_next.last_row    = s1_reg.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        out_reg <= out_next;
    end

    assign row_valid = out_valid_reg;
    assign row       = out_reg;

endmodule

// ===== src/glyph_cell_renderer_top.sv =====
// Top level of the glyph cell renderer: configuration registers, font RAM,
// row sequencer and pixel stage. Depends on gcr_pkg and all modules in src.
//
//   channel   direction   handshake                 payload
//   cmd       in          cmd_valid / cmd_ready     gcr_pkg::cmd_t
//   row       out         row_valid / row_ready     gcr_pkg::row_t
//   cfg       in          cfg_we (write only)       cfg_index, cfg_data
//
// A draw issues one glyph row per cycle while advance is high, set by the single
// read port of the font RAM; a font write or a dropped draw produces no rows.
// A first row passes the hold, sequencer, s1 and output registers in order.
// The next command is held while the current draw issues its rows.
// Reset clears control state only; the font RAM holds nothing until written,
// and there is no clearing pass. A low row_ready holds the pixel stages; once
// they fill, a draw in progress and the command behind it wait too.
module glyph_cell_renderer_top #(
    parameter int GLYPH_HEIGHT  = 16,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_ready,
    input  gcr_pkg::cmd_t                  cmd,
    output logic                           row_valid,
    input  logic                           row_ready,
    output gcr_pkg::row_t                  row,
    input  logic                           cfg_we,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcr_pkg::CFG_DATA_W-1:0] cfg_data
);

    import gcr_pkg::*;

    localparam int ADDR_W = CODE_W + $clog2(GLYPH_HEIGHT);

    logic [CFG_DATA_W-1:0] screen_width_reg, screen_width_next;
    logic [CFG_DATA_W-1:0] screen_height_reg, screen_height_next;
    logic                  frame_ready_reg, frame_ready_next;

    logic                  advance;
    logic                  issue_valid;
    issue_t                issue;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  wr_en;
    logic [BITS_W-1:0]     wr_data;
    logic [BITS_W-1:0]     rd_data;

    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        frame_ready_next   = frame_ready_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_next  = cfg_data;
                REG_SCREEN_HEIGHT: screen_height_next = cfg_data;
                REG_FRAME_READY:   frame_ready_next   = cfg_data[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
            frame_ready_reg   <= 1'b0;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            frame_ready_reg   <= frame_ready_next;
        end
    end

    gcr_row_seq #(
        .GLYPH_HEIGHT  (GLYPH_HEIGHT),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_row_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .frame_ready   (frame_ready_reg),
        .advance       (advance),
        .issue_valid   (issue_valid),
        .issue         (issue),
        .rd_addr       (rd_addr),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    gcr_ram #(
        .DATA_W (BITS_W),
        .DEPTH  (2 ** ADDR_W)
    ) u_font_ram (
        .clk     (clk),
        .we      (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .re      (advance),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gcr_pixel_stage u_pixel_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue_valid (issue_valid),
        .issue       (issue),
        .rd_data     (rd_data),
        .advance     (advance),
        .row_valid   (row_valid),
        .row_ready   (row_ready),
        .row         (row)
    );

endmodule

// ===== test/glyph_cell_renderer_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the glyph cell renderer: mirrors the registers and font RAM,
// predicts the glyph rows of each draw transfer and compares row transfers.
// Depends on gcr_pkg.
module glyph_cell_renderer_checker #(
    parameter int GLYPH_HEIGHT  = 16,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_ready,
    input  gcr_pkg::cmd_t                  cmd,
    input  logic                           row_valid,
    input  logic                           row_ready,
    input  gcr_pkg::row_t                  row,
    input  logic                           cfg_we,
    input  logic [gcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gcr_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             rows_pending
);
    import gcr_pkg::*;

    logic [BITS_W-1:0]     font_model [256*GLYPH_HEIGHT];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic                  ready_reg;
    row_t                  expected_rows [$];

    function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v);
        return (int'(v) > MAX_DIMENSION) ? MAX_DIMENSION : int'(v);
    endfunction

    task automatic predict_cell(input cmd_t c);
        int                 w;
        int                 h;
        int                 px;
        int                 py;
        longint             lin;
        logic [BITS_W-1:0]  bits;
        logic [COLOR_W-1:0] color [8];
        row_t               r;
        w  = clamp_dim(width_reg);
        h  = clamp_dim(height_reg);
        px = int'(c.text_column) * GLYPH_WIDTH;
        py = int'(c.text_row) * GLYPH_HEIGHT;
        // drop the draw when no frame is present or the cell leaves the screen
        if (ready_reg && px + GLYPH_WIDTH <= w && py + GLYPH_HEIGHT <= h)
        begin
            for (int ln = 0; ln < GLYPH_HEIGHT; ln++)
            begin
                bits = font_model[int'(c.char_code) * GLYPH_HEIGHT + ln];
                for (int k = 0; k < 8; k++)
                    color[k] = ((bits & (8'h80 >> k)) != 0) ? c.foreground : c.background;
                lin = longint'(py + ln) * w + px;
                r.pixel_index = lin[INDEX_W-1:0];
                r.pixel0      = color[0];
                r.pixel1      = color[1];
                r.pixel2      = color[2];
                r.pixel3      = color[3];
                r.pixel4      = color[4];
                r.pixel5      = color[5];
                r.pixel6      = color[6];
                r.pixel7      = color[7];
                r.last_row    = (ln == GLYPH_HEIGHT - 1);
                expected_rows.push_back(r);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_row(input row_t got);
        row_t want;
        if (expected_rows.size() == 0)
        begin
            $display("%0t: row transfer expected none actual %h", $time, got);
            mismatches++;
        end
        else
        begin
            want = expected_rows.pop_front();
            compare_field("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
            compare_field("pixel0", want.pixel0, got.pixel0);
            compare_field("pixel1", want.pixel1, got.pixel1);
            compare_field("pixel2", want.pixel2, got.pixel2);
            compare_field("pixel3", want.pixel3, got.pixel3);
            compare_field("pixel4", want.pixel4, got.pixel4);
            compare_field("pixel5", want.pixel5, got.pixel5);
            compare_field("pixel6", want.pixel6, got.pixel6);
            compare_field("pixel7", want.pixel7, got.pixel7);
            compare_field("last_row", 32'(want.last_row), 32'(got.last_row));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = SCREEN_WIDTH_RESET;
            height_reg = SCREEN_HEIGHT_RESET;
            ready_reg  = 1'b0;
            expected_rows.delete();
        end
        else
        begin
            // retire rows first so a stray row is never matched against new work
            if (row_valid && row_ready)
                check_row(row);
            if (cmd_valid && cmd_ready)
            begin
                if (cmd.kind == KIND_FONT)
                begin
                    if (cmd.glyph_line < GLYPH_HEIGHT)
                        font_model[int'(cmd.char_code) * GLYPH_HEIGHT + int'(cmd.glyph_line)]
                            = cmd.glyph_bits;
                end
                else
                    predict_cell(cmd);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg  = cfg_data;
                    REG_SCREEN_HEIGHT: height_reg = cfg_data;
                    REG_FRAME_READY:   ready_reg  = cfg_data[0];
                    default: ;
                endcase
            end
        end
        rows_pending = expected_rows.size();
    end

endmodule

// ===== test/glyph_cell_renderer_top_tb.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for glyph_cell_renderer_top: font loads, character
// draws and screen settings. Depends on gcr_pkg, the RTL and the checker.
module glyph_cell_renderer_top_tb;
    import gcr_pkg::*;

    localparam int GLYPH_HEIGHT    = 16;
    localparam int MAX_DIMENSION   = 4096;
    localparam int SEGMENTS        = 7;
    localparam int SEGMENT_ITEMS   = 30;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_AFTER_ROWS = 300;
    localparam int HOLD_CYCLES     = 300;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_t                  cmd_in;
    logic                  row_valid;
    logic                  row_ready;
    row_t                  row_out;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    rows_pending;

    int                    send_idle;
    int                    recv_idle;
    int                    cur_w;
    int                    cur_h;
    logic [GLYPH_HEIGHT-1:0] lines_written [256];
    bit                    glyph_listed [256];
    logic [CODE_W-1:0]     loaded_codes [$];

    glyph_cell_renderer_top #(
        .GLYPH_HEIGHT  (GLYPH_HEIGHT),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd_in),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row       (row_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    glyph_cell_renderer_checker #(
        .GLYPH_HEIGHT  (GLYPH_HEIGHT),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd_in),
        .row_valid    (row_valid),
        .row_ready    (row_ready),
        .row          (row_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .rows_pending (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("glyph_cell_renderer_top: mismatch");
        $finish;
    end

    // Row sink: random stalls plus one long hold-off to back up the block.
    initial
    begin
        int  row_xfers;
        int  hold_left;
        bit  held;
        row_xfers = 0;
        hold_left = 0;
        held      = 1'b0;
        row_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (row_valid && row_ready)
                row_xfers++;
            if (hold_left > 0)
            begin
                hold_left--;
                row_ready <= 1'b0;
            end
            else if (!held && row_xfers >= HOLD_AFTER_ROWS)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                row_ready <= 1'b0;
            end
            else
                row_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Leave valid high on return; the next call may keep it high with a new command, or a drain lowers it.
    task automatic issue_cmd(input cmd_t c);
        while ($urandom_range(0, 99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_in    <= c;
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic write_font_row(input logic [CODE_W-1:0] code, input logic [3:0] line,
                                  input logic [BITS_W-1:0] bits);
        cmd_t c;
        c.kind        = KIND_FONT;
        c.char_code   = code;
        c.text_column = 9'($urandom_range(0, 511));
        c.text_row    = 8'($urandom_range(0, 255));
        c.foreground  = $urandom;
        c.background  = $urandom;
        c.glyph_line  = line;
        c.glyph_bits  = bits;
        lines_written[code][line] = 1'b1;
        // a glyph becomes drawable only once every row holds data
        if (&lines_written[code] && !glyph_listed[code])
        begin
            glyph_listed[code] = 1'b1;
            loaded_codes.push_back(code);
        end
        issue_cmd(c);
    endtask

    task automatic draw_cell(input logic [CODE_W-1:0] code, input int col, input int trow,
                             input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
        cmd_t c;
        c.kind        = KIND_DRAW;
        c.char_code   = code;
        c.text_column = 9'(col);
        c.text_row    = 8'(trow);
        c.foreground  = fg;
        c.background  = bg;
        c.glyph_line  = 4'($urandom_range(0, 15));
        c.glyph_bits  = 8'($urandom_range(0, 255));
        issue_cmd(c);
    endtask

    task automatic load_glyph(input logic [CODE_W-1:0] code);
        int start;
        start = $urandom_range(0, GLYPH_HEIGHT - 1);
        for (int i = 0; i < GLYPH_HEIGHT; i++)
            write_font_row(code, 4'((start + i) % GLYPH_HEIGHT), 8'($urandom_range(0, 255)));
    endtask

    // Drop valid, wait out every pending row, then cover dropped draws in flight.
    task automatic drain_rows();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic reconfigure(input int w, input int h, input bit rdy);
        drain_rows();
        cfg_write(REG_SCREEN_WIDTH, 13'(w));
        cfg_write(REG_SCREEN_HEIGHT, 13'(h));
        cfg_write(REG_FRAME_READY, 13'(rdy));
        cfg_we <= 1'b0;
        cur_w = w;
        cur_h = h;
    endtask

    initial
    begin
        logic [CODE_W-1:0] code;
        logic [BITS_W-1:0] corner_bits [6];
        int                seg_w [SEGMENTS];
        int                seg_h [SEGMENTS];
        bit                seg_rdy [SEGMENTS];
        int                seg_items;
        int                pick;
        int                eff_w;
        int                eff_h;
        int                cols_fit;
        int                rows_fit;
        int                col;
        int                trow;

        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_in    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        send_idle = 22;
        recv_idle = 68;
        cur_w     = int'(SCREEN_WIDTH_RESET);
        cur_h     = int'(SCREEN_HEIGHT_RESET);
        for (int i = 0; i < 256; i++)
        begin
            lines_written[i] = '0;
            glyph_listed[i]  = 1'b0;
        end
        corner_bits = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
        seg_w   = '{640, 4096, 24, 1000, 1, 8191, 1920};
        seg_h   = '{480, 4096, 32, 752, 4096, 300, 1080};
        seg_rdy = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: one glyph with corner row patterns, then cells at screen edges.
        for (int i = 0; i < GLYPH_HEIGHT; i++)
            write_font_row(8'hFF, 4'(i), (i < 6) ? corner_bits[i] : 8'($urandom_range(0, 255)));
        draw_cell(8'hFF, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
        drain_rows();
        cfg_write(REG_NONE, '1);
        cfg_write(REG_FRAME_READY, 13'd1);
        cfg_we <= 1'b0;
        draw_cell(8'hFF, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
        draw_cell(8'hFF, 79, 29, 32'h0000_0000, 32'hFFFF_FFFF);
        draw_cell(8'hFF, 80, 0, $urandom, $urandom);
        draw_cell(8'hFF, 0, 30, $urandom, $urandom);
        reconfigure(8191, 8191, 1'b1);
        draw_cell(8'hFF, 511, 255, $urandom, $urandom);
        reconfigure(0, 4096, 1'b1);
        draw_cell(8'hFF, 0, 0, $urandom, $urandom);
        reconfigure(8, 16, 1'b1);
        draw_cell(8'hFF, 0, 0, $urandom, $urandom);
        draw_cell(8'hFF, 1, 0, $urandom, $urandom);

        // Random: mostly draws of loaded glyphs, with glyph loads and stray row writes.
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            reconfigure(seg_w[seg], seg_h[seg], seg_rdy[seg]);
            if (seg < 3)
            begin
                send_idle = 22;
                recv_idle = 68;
            end
            else if (seg < 5)
            begin
                send_idle = 68;
                recv_idle = 22;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            seg_items = 0;
            while (seg_items < SEGMENT_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 6)
                begin
                    code = (loaded_codes.size() < 2) ? 8'h00 : 8'($urandom_range(0, 255));
                    load_glyph(code);
                    seg_items += GLYPH_HEIGHT;
                end
                else if (pick < 20)
                begin
                    write_font_row(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                                   8'($urandom_range(0, 255)));
                    seg_items++;
                end
                else
                begin
                    code     = loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
                    eff_w    = (cur_w > MAX_DIMENSION) ? MAX_DIMENSION : cur_w;
                    eff_h    = (cur_h > MAX_DIMENSION) ? MAX_DIMENSION : cur_h;
                    cols_fit = eff_w / GLYPH_WIDTH;
                    rows_fit = eff_h / GLYPH_HEIGHT;
                    // keep most cells on screen, let the rest land anywhere
                    if ($urandom_range(0, 3) != 0 && cols_fit > 0 && rows_fit > 0)
                    begin
                        col  = $urandom_range(0, (cols_fit > 512) ? 511 : cols_fit - 1);
                        trow = $urandom_range(0, (rows_fit > 256) ? 255 : rows_fit - 1);
                    end
                    else
                    begin
                        col  = $urandom_range(0, 511);
                        trow = $urandom_range(0, 255);
                    end
                    draw_cell(code, col, trow, $urandom, $urandom);
                    seg_items++;
                end
            end
        end

        drain_rows();
        repeat (12) @(posedge clk);
        if (mismatches == 0 && rows_pending == 0)
            $display("glyph_cell_renderer_top: match");
        else
            $display("glyph_cell_renderer_top: mismatch");
        $finish;
    end

endmodule
